### rtl/assert_macros.svh
// Assertion macros shared by the deque RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks that a condition holds at every clock edge outside reset.
`define DEQ_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Checks that a consequent holds in the cycle after its trigger.
`define DEQ_ASSERT_NEXT(lbl, clk, rstn, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cons)) else $error(msg);

// Checks that a consequent holds in the same cycle as its trigger.
`define DEQ_ASSERT_SAME(lbl, clk, rstn, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |-> (cons)) else $error(msg);

`else

`define DEQ_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define DEQ_ASSERT_NEXT(lbl, clk, rstn, trig, cons, msg)
`define DEQ_ASSERT_SAME(lbl, clk, rstn, trig, cons, msg)

`endif

`endif

### rtl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// No dependencies; imported by deq_cell, double_ended_queue, deque_checker and tb.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_POP_FRONT  = 3'd1,
    CMD_PUSH_REAR  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_COUNT      = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What a cell loads on the coming edge.
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_FROM_LEFT  = 2'd1,
    CELL_FROM_RIGHT = 2'd2,
    CELL_LOAD       = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     rd_sel;
  } cell_ctrl_t;

endpackage

### rtl/deq_cell.sv
// One storage cell of the deque row: holds one element in queue order.
// Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_cell import deq_pkg::*; (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  input  logic [DATA_W-1:0] load_data,
  output logic [DATA_W-1:0] data_o,
  output logic [DATA_W-1:0] tap_o
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    case (ctrl.op)
      CELL_FROM_LEFT:  data_nxt = left_data;
      CELL_FROM_RIGHT: data_nxt = right_data;
      CELL_LOAD:       data_nxt = load_data;
      default:         data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  // Only the selected cell drives its value onto the shared read OR.
  assign tap_o  = ctrl.rd_sel ? data_r : '0;

endmodule

### rtl/double_ended_queue.sv
// Top level of the bounded double-ended queue built as a row of shifting cells.
// Depends on deq_pkg, deq_cell and assert_macros.svh.
//
//   Channel  | Direction | tdata                                  | tuser
//   ---------+-----------+----------------------------------------+-------------
//   in_      | sink      | [31:0] value                           | [2:0] cmd
//   out_     | source    | [31:0] popped_value, [36:32] count     | [1:0] status
//
// Every command completes when its transaction is accepted; a new transaction can be taken each cycle.
// The result appears in the output register in the cycle after its input transaction.
// Throughput is set by the output register: input is taken while it is empty
// or being drained in the same cycle.
// Reset (rst_n low, synchronous) empties the queue and the output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module double_ended_queue import deq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [2:0]  in_tuser,   // [2:0] cmd
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] popped_value, [36:32] element_count, rest zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  // The row keeps elements in queue order: cell 0 is the front and cell
  // count-1 is the rear. A push or pop at the front shifts the whole row by
  // one place, while rear operations touch only the cell at the rear.

  logic                in_acc;
  cmd_t                cmd;
  logic [DATA_W-1:0]   in_value;

  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic                full;
  logic                empty;
  logic [IDX_W-1:0]    rear_idx;
  logic [IDX_W-1:0]    tail_idx;

  cell_ctrl_t          ctrl      [DEPTH];
  logic [DATA_W-1:0]   cell_data [DEPTH];
  logic [DATA_W-1:0]   cell_tap  [DEPTH];
  logic [DATA_W-1:0]   rd_data;

  status_t             status;
  logic [DATA_W-1:0]   popped;

  logic                out_valid_r;
  logic [DATA_W-1:0]   out_popped_r;
  logic [CNT_W-1:0]    out_count_r;
  status_t             out_status_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign cmd       = cmd_t'(in_tuser);
  assign in_value  = in_tdata;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  // Rear element sits one below the count; the free slot at the count.
  assign rear_idx  = IDX_W'(count_r - CNT_W'(1));
  assign tail_idx  = count_r[IDX_W-1:0];

  // The selected cell's tap is the only nonzero one, so an OR picks it.
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_data = rd_data | cell_tap[i];
    end
  end

  // A cell is selected only by a pop that finds an element, so the OR of the
  // taps is already zero for every other command.
  assign popped = rd_data;

  // Command decode: sets the cell controls, the next count and the status.
  always_comb begin
    count_nxt = count_r;
    status    = ST_OK;
    for (int i = 0; i < DEPTH; i++) begin
      ctrl[i].op     = CELL_HOLD;
      ctrl[i].rd_sel = 1'b0;
    end
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
          for (int i = 0; i < DEPTH; i++) begin
            ctrl[i].op = in_acc ? CELL_FROM_LEFT : CELL_HOLD;
          end
        end
      end
      CMD_PUSH_REAR: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
          for (int i = 0; i < DEPTH; i++) begin
            if (in_acc && tail_idx == IDX_W'(i)) begin
              ctrl[i].op = CELL_LOAD;
            end
          end
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          count_nxt      = count_r - CNT_W'(1);
          ctrl[0].rd_sel = 1'b1;
          for (int i = 0; i < DEPTH; i++) begin
            ctrl[i].op = in_acc ? CELL_FROM_RIGHT : CELL_HOLD;
          end
        end
      end
      CMD_POP_REAR: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          for (int i = 0; i < DEPTH; i++) begin
            ctrl[i].rd_sel = (rear_idx == IDX_W'(i));
          end
        end
      end
      default: begin
        // Count report and unused codes change nothing.
      end
    endcase
  end

  // The cell row. Cell 0 takes the pushed value when the row shifts toward
  // the rear; the last cell keeps its own value when the row shifts forward.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] left_in;
    logic [DATA_W-1:0] right_in;

    if (g == 0) begin : g_first
      assign left_in = in_value;
    end else begin : g_inner_l
      assign left_in = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_in = cell_data[g];
    end else begin : g_inner_r
      assign right_in = cell_data[g+1];
    end

    deq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl[g]),
      .left_data  (left_in),
      .right_data (right_in),
      .load_data  (in_value),
      .data_o     (cell_data[g]),
      .tap_o      (cell_tap[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; loaded only with an accepted transaction.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_popped_r <= popped;
      out_count_r  <= count_nxt;
      out_status_r <= status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_count_r, out_popped_r};
  assign out_tuser  = out_status_r;

  `DEQ_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CNT_W'(DEPTH), "count above depth")
  `DEQ_ASSERT_NEXT(a_push_grows, clk, rst_n, in_acc && !full && (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_REAR), count_r == $past(count_r) + CNT_W'(1), "accepted push did not grow count")
  `DEQ_ASSERT_NEXT(a_pop_shrinks, clk, rst_n, in_acc && !empty && (cmd == CMD_POP_FRONT || cmd == CMD_POP_REAR), count_r == $past(count_r) - CNT_W'(1), "accepted pop did not shrink count")
  `DEQ_ASSERT_SAME(a_full_flag, clk, rst_n, out_valid_r && out_status_r == ST_FULL, out_count_r == CNT_W'(DEPTH), "full status with room left")
  `DEQ_ASSERT_SAME(a_empty_flag, clk, rst_n, out_valid_r && out_status_r == ST_EMPTY, out_count_r == '0 && out_popped_r == '0, "empty status with elements held")

endmodule

### verif/deque_checker.sv
// Checker for the double-ended queue: watches both stream channels and scores results.
// Depends on deq_pkg; instantiated by tb next to the block under test.
`timescale 1ns / 1ps

module deque_checker import deq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          fail_count,
  output int          pending,
  output int          checked,
  output int          refused_pushes,
  output int          empty_pops
);

  typedef struct packed {
    logic [DATA_W-1:0] popped;
    logic [CNT_W-1:0]  count;
    status_t           status;
  } deque_result_t;

  deque_result_t     awaited_q[$];
  logic [DATA_W-1:0] ring [DEPTH];
  logic [IDX_W-1:0]  front;
  int unsigned       held;
  int                errors, results_seen, full_seen, empty_seen;

  // Applies one command to the shadow deque and returns the result it should produce.
  function automatic deque_result_t apply_command(logic [CMD_W-1:0] cmd,
                                                  logic [DATA_W-1:0] value);
    deque_result_t    r;
    logic [IDX_W-1:0] slot;
    r.popped = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (held == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          front = front - 1'b1;
          ring[front] = value;
          held++;
        end
      end
      CMD_PUSH_REAR: begin
        if (held == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot = front + IDX_W'(held);
          ring[slot] = value;
          held++;
        end
      end
      CMD_POP_FRONT: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped = ring[front];
          front = front + 1'b1;
          held--;
        end
      end
      CMD_POP_REAR: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          slot = front + IDX_W'(held - 1);
          r.popped = ring[slot];
          held--;
        end
      end
      default: begin
      end
    endcase
    r.count = CNT_W'(held);
    return r;
  endfunction

  task automatic check_field(string name, logic [39:0] want, logic [39:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    deque_result_t want;
    if (!rst_n) begin
      awaited_q.delete();
      front = '0;
      held = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got tdata %h tuser %h",
                   $time, out_tdata, out_tuser);
          errors++;
        end else begin
          want = awaited_q[0];
          awaited_q.delete(0);
          check_field("popped_value", 40'(want.popped), 40'(out_tdata[31:0]));
          check_field("element_count", 40'(want.count), 40'(out_tdata[36:32]));
          check_field("tdata padding", 40'd0, 40'(out_tdata[39:37]));
          check_field("status", 40'(want.status), 40'(out_tuser));
          results_seen++;
        end
      end
      if (in_tvalid && in_tready) begin
        want = apply_command(in_tuser, in_tdata);
        if (want.status == ST_FULL) full_seen++;
        if (want.status == ST_EMPTY) empty_seen++;
        awaited_q.push_back(want);
      end
    end
    fail_count     <= errors;
    pending        <= awaited_q.size();
    checked        <= results_seen;
    refused_pushes <= full_seen;
    empty_pops     <= empty_seen;
  end

endmodule

### verif/tb.sv
// Top of the double-ended queue testbench: clock, reset, stimulus, idling and verdict.
// Depends on deq_pkg, double_ended_queue and deque_checker.
`timescale 1ns / 1ps

module tb;
  import deq_pkg::*;

  // Command codes the block does not define; they must behave as no-ops.
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  // Random phases lean toward filling, draining, or neither.
  localparam int PHASE_FILL  = 0;
  localparam int PHASE_DRAIN = 1;
  localparam int PHASE_MIXED = 2;

  localparam int RANDOM_ITEMS = 1350;
  // A correct run never sits idle longer than the longest stall plus the longest gap.
  localparam int IDLE_LIMIT   = 2000;
  // A margin past the result register is allowed for stragglers.
  localparam int DRAIN_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;    // [31:0] value
  logic [2:0]  in_tuser = '0;    // [2:0] cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;        // [31:0] popped_value, [36:32] element_count, rest zero
  logic [1:0]  out_tuser;        // [1:0] status

  // When set, neither side idles, so back-to-back transactions are exercised.
  logic steady = 1'b0;
  int   idle_cycles = 0;
  int   fail_count, pending, checked, refused_pushes, empty_pops;

  always #5 clk = ~clk;

  double_ended_queue u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  deque_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .fail_count     (fail_count),
    .pending        (pending),
    .checked        (checked),
    .refused_pushes (refused_pushes),
    .empty_pops     (empty_pops)
  );

  // Idle lengths: mostly none or short, now and then a long pause.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 4);
  endfunction

  // Element values: mostly random words, with the signed extremes, zero and all ones mixed in.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(11))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Presents one transaction and holds it until the block takes it. Valid stays
  // high into the next transaction unless a gap is chosen, so it is never lowered
  // and raised within one time step.
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [31:0] value);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result-side back-pressure: runs of ready broken by stalls of random length.
  initial begin
    int run_len, stall_len;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      run_len   = $urandom_range(12, 1);
      stall_len = steady ? 0 : pick_gap();
      out_tready <= 1'b1;
      repeat (run_len) @(posedge clk);
      if (stall_len > 0) begin
        out_tready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // Watchdog: a run that stops moving in both directions is a failure.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles, %0d results outstanding.",
                 IDLE_LIMIT, pending);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int               sent, phase_len, mode, roll, push_pct, pop_pct;
    logic [CMD_W-1:0] cmd;
    sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening: pops on an empty deque, the count command, the unused
    // codes, the signed extremes at both ends, then a fill past full.
    send_command(CMD_POP_FRONT, 32'hFFFF_FFFF);
    send_command(CMD_POP_REAR, 32'h0000_0000);
    send_command(CMD_COUNT, 32'hA5A5_A5A5);
    send_command(CMD_SPARE_FIRST, 32'h5A5A_5A5A);
    send_command(CMD_SPARE_LAST, 32'hFFFF_FFFF);
    send_command(CMD_PUSH_REAR, 32'h7FFF_FFFF);
    // A front push with the head at slot zero wraps the head index below zero.
    send_command(CMD_PUSH_FRONT, 32'h8000_0000);
    send_command(CMD_POP_REAR, 32'h0000_0000);
    send_command(CMD_POP_FRONT, 32'h0000_0000);
    for (int i = 0; i < DEPTH; i++) begin
      send_command((i % 2) ? CMD_PUSH_FRONT : CMD_PUSH_REAR,
                   (i < 4) ? ~32'(i) : pick_value());
    end
    // The deque is full now: both pushes must be refused without a change.
    send_command(CMD_PUSH_FRONT, 32'h1234_5678);
    send_command(CMD_PUSH_REAR, 32'h8765_4321);
    send_command(CMD_COUNT, 32'h0000_0000);

    // Random phases. Fill and drain phases drive the deque to its bounds many
    // times over, so full and empty cases keep recurring with random contents.
    while (sent < RANDOM_ITEMS) begin
      mode      = $urandom_range(PHASE_MIXED, PHASE_FILL);
      phase_len = $urandom_range(60, 10);
      steady    <= ($urandom_range(3) == 0);
      push_pct  = (mode == PHASE_FILL) ? 70 : (mode == PHASE_DRAIN) ? 20 : 45;
      pop_pct   = (mode == PHASE_FILL) ? 20 : (mode == PHASE_DRAIN) ? 70 : 45;
      repeat (phase_len) begin
        roll = $urandom_range(99);
        if (roll < push_pct) begin
          cmd = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
        end else if (roll < push_pct + pop_pct) begin
          cmd = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_REAR;
        end else if (roll < 97) begin
          cmd = CMD_COUNT;
        end else begin
          cmd = CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
        end
        send_command(cmd, pick_value());
        // Unused codes are no-ops and do not count toward the random total.
        if (cmd < CMD_SPARE_FIRST) sent++;
      end
    end
    in_tvalid <= 1'b0;
    steady    <= 1'b0;

    // Let the last prediction register before waiting for the results to drain.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d random commands plus a directed opening; %0d results checked.",
             sent, checked);
    $display("Refused pushes on a full deque: %0d, pops on an empty deque: %0d.",
             refused_pushes, empty_pops);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/deq_pkg.sv
rtl/deq_cell.sv
rtl/double_ended_queue.sv
verif/deque_checker.sv
verif/tb.sv
